>>> sv/reb_pkg.sv
// ----------------------------------------------------------------------------
// reb_pkg: shared types and constants for the rotary encoder/button input
// Transaction structs, configuration indexes and the quadrature decode table.
// ----------------------------------------------------------------------------
package reb_pkg;

    localparam int POS_WIDTH  = 16;
    localparam int TIME_WIDTH = 32;

    typedef logic [TIME_WIDTH-1:0]       t_time;
    typedef logic signed [POS_WIDTH-1:0] t_pos;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_EDGE_LOCKOUT = 2'd0,
        CFG_DEBOUNCE     = 2'd1,
        CFG_LONG_PRESS   = 2'd2
    } t_cfg_idx;

    localparam logic [7:0]  RST_EDGE_LOCKOUT = 8'd5;
    localparam logic [15:0] RST_DEBOUNCE     = 16'd50;
    localparam logic [15:0] RST_LONG_PRESS   = 16'd800;

    // reset pin pair: both encoder pins idle high
    localparam logic [1:0] PIN_PAIR_IDLE = 2'b11;

    // input function codes
    localparam logic FUNC_PIN_EVENT = 1'b0;
    localparam logic FUNC_POLL      = 1'b1;

    // rotation step codes
    localparam logic signed [1:0] DIR_NONE = 2'sb00;
    localparam logic signed [1:0] DIR_UP   = 2'sb01;
    localparam logic signed [1:0] DIR_DOWN = 2'sb11;

    typedef struct packed {
        logic                  func;
        logic [31:0]           time_ms;
        logic                  clk_level;
        logic                  dt_level;
        logic                  sw_level;
    } t_in;

    typedef struct packed {
        logic signed [1:0]     rotate_dir;
        logic                  click;
        logic                  long_press;
        logic signed [15:0]    position;
    } t_out;

    typedef struct packed {
        logic click;
        logic long_press;
    } t_btn_evt;

    // quadrature transition decode: {previous pair, new pair} -> step
    function automatic logic signed [1:0] quad_step(input logic [3:0] code);
        logic signed [1:0] step;
        step = DIR_NONE;
        if (code inside {4'b1101, 4'b0100, 4'b0010, 4'b1011}) begin
            step = DIR_UP;
        end else if (code inside {4'b1110, 4'b0111, 4'b0001, 4'b1000}) begin
            step = DIR_DOWN;
        end
        return step;
    endfunction

endpackage

>>> sv/reb_button.sv
// ----------------------------------------------------------------------------
// reb_button: push-button debounce and click / long press classifier
// Updates press state on each poll and flags clicks and long presses.
// ----------------------------------------------------------------------------
module reb_button (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_poll,
    input  reb_pkg::t_time    i_time,
    input  logic              i_sw_level,
    input  logic [15:0]       i_debounce,
    input  logic [15:0]       i_long_press,
    output reb_pkg::t_btn_evt o_evt
);
    import reb_pkg::*;

    t_time r_press_time, n_press_time;
    t_time r_release_time, n_release_time;
    logic  r_was_down, n_was_down;
    logic  r_reported, n_reported;

    t_time    press_dur;
    t_time    since_release;
    t_time    debounce_w;
    t_time    long_w;
    logic     pressed;
    t_btn_evt evt;

    assign pressed       = ~i_sw_level;
    assign press_dur     = i_time - r_press_time;
    assign since_release = i_time - r_release_time;
    assign debounce_w    = TIME_WIDTH'(i_debounce);
    assign long_w        = TIME_WIDTH'(i_long_press);

    always_comb begin
        n_press_time   = r_press_time;
        n_release_time = r_release_time;
        n_was_down     = r_was_down;
        n_reported     = r_reported;
        evt            = '0;
        if (i_poll) begin
            if (pressed != r_was_down) begin
                if (pressed) begin
                    if (since_release > debounce_w) begin
                        n_press_time = i_time;
                        n_reported   = 1'b0;
                    end
                end else if (press_dur > debounce_w) begin
                    n_release_time = i_time;
                    if (!r_reported) begin
                        // past debounce already, so anything short of long is a click
                        if (press_dur >= long_w) begin
                            evt.long_press = 1'b1;
                        end else begin
                            evt.click = 1'b1;
                        end
                        n_reported = 1'b1;
                    end
                end
                // bounces still track the level
                n_was_down = pressed;
            end else if (pressed && !r_reported && press_dur >= long_w) begin
                evt.long_press = 1'b1;
                n_reported     = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_time   <= '0;
            r_release_time <= '0;
            r_was_down     <= 1'b0;
            r_reported     <= 1'b0;
        end else begin
            r_press_time   <= n_press_time;
            r_release_time <= n_release_time;
            r_was_down     <= n_was_down;
            r_reported     <= n_reported;
        end
    end

    assign o_evt = evt;

endmodule

>>> sv/rotary_encoder_button_input.sv
// ----------------------------------------------------------------------------
// rotary_encoder_button_input: quadrature encoder and button qualifier
// Decodes encoder pin events into a position and reports steps and button
// clicks or long presses on polls.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries pin-change
//   events and polls. Every input transaction gives exactly one output
//   transaction on o_out_valid / i_out_ready / o_out_data.
//   A transaction is captured in an input register, processed against the
//   state registers, and lands in the output register, which drives
//   o_out_valid. Throughput is one transaction per cycle while the receiver
//   does not stall; the state update is a single pass of 32-bit time
//   subtracts and compares plus a 16-bit add.
//   When the receiver stalls, the output register holds its transaction and
//   the input register keeps one more; o_in_ready drops once both are full.
//   Reset clears position, timestamps and button state, restores the
//   configuration defaults (lockout 5, debounce 50, long press 800 ms) and
//   empties both registers. Configuration is written through i_cfg_we /
//   i_cfg_index / i_cfg_data, and the user must write it only while no
//   transaction is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module rotary_encoder_button_input (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  reb_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output reb_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data
);
    import reb_pkg::*;

    // configuration
    logic [7:0]  r_edge_lockout;
    logic [15:0] r_debounce;
    logic [15:0] r_long_press;

    // pipeline registers
    logic r_in_valid;
    t_in  r_in;
    logic r_out_valid;
    t_out r_out, n_out;

    // encoder state
    t_pos       r_enc_pos, n_enc_pos;
    t_pos       r_rep_pos, n_rep_pos;
    logic [1:0] r_last_pair, n_last_pair;
    t_time      r_last_edge, n_last_edge;

    logic              advance;
    logic              step;
    logic              poll;
    t_time             now;
    t_time             since_edge;
    logic [1:0]        pair;
    logic signed [1:0] qstep;
    t_pos              pos_diff;
    t_btn_evt          btn_evt;

    assign advance    = ~r_out_valid | i_out_ready;
    assign step       = r_in_valid & advance;
    assign poll       = step & (r_in.func == FUNC_POLL);
    assign o_in_ready = ~r_in_valid | advance;

    assign now        = TIME_WIDTH'(r_in.time_ms);
    assign since_edge = now - r_last_edge;
    assign pair       = {r_in.clk_level, r_in.dt_level};
    assign qstep      = quad_step({r_last_pair, pair});
    assign pos_diff   = r_enc_pos - r_rep_pos;

    reb_button u_button (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_poll       (poll),
        .i_time       (now),
        .i_sw_level   (r_in.sw_level),
        .i_debounce   (r_debounce),
        .i_long_press (r_long_press),
        .o_evt        (btn_evt)
    );

    always_comb begin
        n_enc_pos   = r_enc_pos;
        n_rep_pos   = r_rep_pos;
        n_last_pair = r_last_pair;
        n_last_edge = r_last_edge;
        n_out       = '0;
        if (r_in.func == FUNC_PIN_EVENT) begin
            // edges inside the lockout window are dropped entirely
            if (since_edge >= TIME_WIDTH'(r_edge_lockout)) begin
                n_last_edge = now;
                n_last_pair = pair;
                if (qstep == DIR_UP) begin
                    n_enc_pos = r_enc_pos + t_pos'(1);
                end else if (qstep == DIR_DOWN) begin
                    n_enc_pos = r_enc_pos - t_pos'(1);
                end
            end
        end else begin
            if (r_enc_pos != r_rep_pos) begin
                n_out.rotate_dir = pos_diff[POS_WIDTH-1] ? DIR_DOWN : DIR_UP;
                n_rep_pos        = r_enc_pos;
            end
            n_out.click      = btn_evt.click;
            n_out.long_press = btn_evt.long_press;
        end
        n_out.position = 16'(n_enc_pos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_lockout <= RST_EDGE_LOCKOUT;
            r_debounce     <= RST_DEBOUNCE;
            r_long_press   <= RST_LONG_PRESS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EDGE_LOCKOUT: r_edge_lockout <= i_cfg_data[7:0];
                CFG_DEBOUNCE:     r_debounce     <= i_cfg_data;
                CFG_LONG_PRESS:   r_long_press   <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_enc_pos   <= '0;
            r_rep_pos   <= '0;
            r_last_pair <= PIN_PAIR_IDLE;
            r_last_edge <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (step) begin
                r_enc_pos   <= n_enc_pos;
                r_rep_pos   <= n_rep_pos;
                r_last_pair <= n_last_pair;
                r_last_edge <= n_last_edge;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (step) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> sv/reb_checker.sv
// ----------------------------------------------------------------------------
// reb_checker: port-level checks for rotary_encoder_button_input
// Watches the output channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module reb_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input reb_pkg::t_out o_out_data
);
    import reb_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output transaction changed while stalled");

    a_click_xor_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.click && o_out_data.long_press))
        else $error("click and long press in one transaction");

    a_dir_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.rotate_dir != 2'b10)
        else $error("invalid rotation step code");

    // nothing in flight right after reset, and nothing comes out of nowhere
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_in_valid && o_in_ready) && !$past(o_out_valid, 1)
            && !$past(o_out_valid, 2) && !$past(i_in_valid && o_in_ready, 2)
            && $past(i_rst_n, 2) |-> !o_out_valid)
        else $error("output transaction without an input transaction");

endmodule

bind rotary_encoder_button_input reb_checker u_reb_checker (.*);

>>> tb/encoder_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_result_checker: prediction and comparison for the encoder/button block
// Watches the input, output and register ports, keeps its own copy of the
// position, edge and button state, and queues one expected result per input
// transaction. Each output transaction is checked field by field against the
// oldest queued result.
// ----------------------------------------------------------------------------
module encoder_result_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  reb_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  reb_pkg::t_out i_out_data,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    output int            o_fail_count,
    output int            o_pending,
    output int            o_checked,
    output int            o_clicks,
    output int            o_longs
);
    import reb_pkg::*;

    localparam int REPORT_LIMIT = 20;

    // register copies
    logic [7:0]  lockout_ms;
    logic [15:0] debounce_ms;
    logic [15:0] long_ms;

    // encoder and button state
    t_pos        pos_acc;
    t_pos        pos_reported;
    logic [1:0]  pins_prev;
    t_time       edge_stamp;
    t_time       press_stamp;
    t_time       release_stamp;
    logic        btn_held;
    logic        press_flagged;

    t_out        expected_q[$];

    // forward rotation visits 11 -> 01 -> 00 -> 10 -> 11
    function automatic logic [1:0] fwd_next(input logic [1:0] pins);
        logic [1:0] nxt;
        case (pins)
            2'b11:   nxt = 2'b01;
            2'b01:   nxt = 2'b00;
            2'b00:   nxt = 2'b10;
            default: nxt = 2'b11;
        endcase
        return nxt;
    endfunction

    task automatic predict_result(input t_in it, output t_out res);
        t_time      since;
        t_time      held_for;
        logic [1:0] pins;
        t_pos       delta;
        logic       pressed;
        res = '0;
        res.rotate_dir = DIR_NONE;
        if (it.func == FUNC_PIN_EVENT) begin
            since = it.time_ms - edge_stamp;
            // edges inside the lockout window leave everything untouched
            if (since >= t_time'(lockout_ms)) begin
                edge_stamp = it.time_ms;
                pins = {it.clk_level, it.dt_level};
                if (pins == fwd_next(pins_prev)) begin
                    pos_acc = pos_acc + t_pos'(1);
                end else if (pins_prev == fwd_next(pins)) begin
                    pos_acc = pos_acc - t_pos'(1);
                end
                pins_prev = pins;
            end
        end else begin
            pressed = (it.sw_level == 1'b0);
            if (pos_acc != pos_reported) begin
                delta = pos_acc - pos_reported;
                res.rotate_dir = delta[15] ? DIR_DOWN : DIR_UP;
                pos_reported = pos_acc;
            end
            if (pressed != btn_held) begin
                if (pressed) begin
                    since = it.time_ms - release_stamp;
                    if (since > t_time'(debounce_ms)) begin
                        press_stamp = it.time_ms;
                        press_flagged = 1'b0;
                    end
                end else begin
                    held_for = it.time_ms - press_stamp;
                    if (held_for > t_time'(debounce_ms)) begin
                        release_stamp = it.time_ms;
                        if (!press_flagged) begin
                            // held_for already exceeds the debounce time here
                            if (held_for >= t_time'(long_ms)) begin
                                res.long_press = 1'b1;
                            end else begin
                                res.click = 1'b1;
                            end
                            press_flagged = 1'b1;
                        end
                    end
                end
                btn_held = pressed;
            end else if (pressed && !press_flagged) begin
                held_for = it.time_ms - press_stamp;
                if (held_for >= t_time'(long_ms)) begin
                    res.long_press = 1'b1;
                    press_flagged = 1'b1;
                end
            end
        end
        res.position = pos_acc;
    endtask

    task automatic check_field(input string fname, input logic signed [16:0] want_v,
                               input logic signed [16:0] got_v);
        if (got_v !== want_v) begin
            if (o_fail_count < REPORT_LIMIT) begin
                $error("%s: expected %0d, got %0d", fname, want_v, got_v);
            end
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            lockout_ms    = RST_EDGE_LOCKOUT;
            debounce_ms   = RST_DEBOUNCE;
            long_ms       = RST_LONG_PRESS;
            pos_acc       = '0;
            pos_reported  = '0;
            pins_prev     = PIN_PAIR_IDLE;
            edge_stamp    = '0;
            press_stamp   = '0;
            release_stamp = '0;
            btn_held      = 1'b0;
            press_flagged = 1'b0;
            expected_q.delete();
            o_pending     = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_EDGE_LOCKOUT: lockout_ms  = i_cfg_data[7:0];
                    CFG_DEBOUNCE:     debounce_ms = i_cfg_data;
                    CFG_LONG_PRESS:   long_ms     = i_cfg_data;
                    default: ;  // no register behind this index
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                predict_result(i_in_data, want);
                expected_q.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    if (o_fail_count < REPORT_LIMIT) begin
                        $error("output transaction with no input transaction pending");
                    end
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("rotate_dir", 17'(want.rotate_dir),
                                17'(i_out_data.rotate_dir));
                    check_field("click", 17'(want.click), 17'(i_out_data.click));
                    check_field("long_press", 17'(want.long_press),
                                17'(i_out_data.long_press));
                    check_field("position", 17'(want.position),
                                17'(i_out_data.position));
                    o_checked++;
                    if (want.click) begin
                        o_clicks++;
                    end
                    if (want.long_press) begin
                        o_longs++;
                    end
                end
            end
            o_pending = expected_q.size();
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for rotary_encoder_button_input
// Drives pin events and polls with random gaps and output back-pressure,
// walks the registers through several settings including the extremes, runs
// a burst of back-to-back edges, and leaves checking to the checker.
// ----------------------------------------------------------------------------
module tb;
    import reb_pkg::*;

    localparam logic [1:0] CFG_SPARE      = 2'd3;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         RX_HOLD_CYCLES = 40;
    localparam int         BURST_STEPS    = 64;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in         in_data;
    logic        out_valid;
    logic        out_ready;
    t_out        out_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    int          fail_count;
    int          pending;
    int          checked;
    int          clicks;
    int          longs;

    int          idle_cycles;
    int          items_sent;
    int          settings_used;
    int          rx_hold_asked;
    int          rx_hold_done;
    bit          no_idle;
    bit          spin_fwd;
    t_time       now_ms;
    logic [1:0]  quad_idx;
    logic [1:0]  burst_pins;
    logic        sw_pin;
    logic [7:0]  lockout_cur;
    logic [15:0] debounce_cur;
    logic [15:0] long_cur;

    rotary_encoder_button_input dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    encoder_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_clicks     (clicks),
        .o_longs      (longs)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // pin levels along one forward turn of the encoder
    function automatic logic [1:0] quad_pins(input logic [1:0] idx);
        logic [1:0] pins;
        case (idx)
            2'd0:    pins = 2'b11;
            2'd1:    pins = 2'b01;
            2'd2:    pins = 2'b00;
            default: pins = 2'b10;
        endcase
        return pins;
    endfunction

    function automatic t_in make_item(input logic func, input t_time stamp,
                                      input logic clk_pin, input logic dt_pin,
                                      input logic sw);
        t_in it;
        it.func      = func;
        it.time_ms   = stamp;
        it.clk_level = clk_pin;
        it.dt_level  = dt_pin;
        it.sw_level  = sw;
        return it;
    endfunction

    task automatic send_item(input t_in item);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        repeat (gap) @(negedge clk) in_valid <= 1'b0;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // registers change only with nothing in flight
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(negedge clk) in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk) cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic [15:0] lock_word, input logic [15:0] deb,
                             input logic [15:0] lng);
        write_reg(CFG_EDGE_LOCKOUT, lock_word);
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_LONG_PRESS, lng);
        lockout_cur  = lock_word[7:0];
        debounce_cur = deb;
        long_cur     = lng;
        settings_used++;
    endtask

    task automatic run_random_phase(input int n);
        t_in   item;
        int    r;
        t_time delta;
        for (int k = 0; k < n; k++) begin
            no_idle = (k % 90) < 12;
            r = $urandom_range(0, 99);
            item.func = (r < 55) ? FUNC_PIN_EVENT : FUNC_POLL;
            r = $urandom_range(0, 99);
            if (r < 2) begin
                // arbitrary jump, also wraps the timestamp
                delta = $urandom();
            end else if (item.func == FUNC_PIN_EVENT) begin
                delta = (r < 70) ? $urandom_range(0, 2 * int'(lockout_cur) + 2)
                                 : $urandom_range(0, 3);
            end else if (r < 50) begin
                delta = $urandom_range(0, 2 * int'(debounce_cur) + 2);
            end else if (r < 80) begin
                delta = $urandom_range(0, int'(long_cur) + int'(long_cur) / 2 + 2);
            end else begin
                delta = $urandom_range(0, 8);
            end
            now_ms = now_ms + delta;
            item.time_ms = now_ms;
            if (item.func == FUNC_PIN_EVENT) begin
                if ($urandom_range(0, 9) < 8) begin
                    if ($urandom_range(0, 15) == 0) begin
                        spin_fwd = ~spin_fwd;
                    end
                    quad_idx = spin_fwd ? quad_idx + 2'd1 : quad_idx - 2'd1;
                    {item.clk_level, item.dt_level} = quad_pins(quad_idx);
                end else begin
                    // contact noise: repeats, skipped states
                    {item.clk_level, item.dt_level} = 2'($urandom_range(0, 3));
                end
                item.sw_level = 1'($urandom_range(0, 1));
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    sw_pin = ~sw_pin;
                end
                item.sw_level = sw_pin;
                {item.clk_level, item.dt_level} = 2'($urandom_range(0, 3));
            end
            send_item(item);
        end
        no_idle = 1'b0;
    endtask

    // output side: random stalls per transaction, plus requested long hold-offs
    initial begin : rx_side
        int stall;
        wait (rst_n === 1'b1);
        forever begin
            if (rx_hold_done < rx_hold_asked) begin
                rx_hold_done++;
                stall = RX_HOLD_CYCLES;
            end else if (no_idle) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 6);
            end
            repeat (stall) @(negedge clk) out_ready <= 1'b0;
            @(negedge clk) out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (!in_valid && pending == 0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_ready     = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        items_sent    = 0;
        settings_used = 1;
        rx_hold_asked = 0;
        rx_hold_done  = 0;
        no_idle       = 1'b0;
        spin_fwd      = 1'b1;
        lockout_cur   = RST_EDGE_LOCKOUT;
        debounce_cur  = RST_DEBOUNCE;
        long_cur      = RST_LONG_PRESS;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // directed, reset settings
        send_item(make_item(FUNC_PIN_EVENT, 32'd2, 1'b0, 1'b1, 1'b1));  // lockout after reset
        send_item(make_item(FUNC_PIN_EVENT, 32'd10, 1'b0, 1'b1, 1'b1));
        send_item(make_item(FUNC_PIN_EVENT, 32'd12, 1'b0, 1'b0, 1'b1));  // inside lockout
        send_item(make_item(FUNC_PIN_EVENT, 32'd20, 1'b0, 1'b0, 1'b0));
        send_item(make_item(FUNC_PIN_EVENT, 32'd30, 1'b1, 1'b0, 1'b1));
        send_item(make_item(FUNC_PIN_EVENT, 32'd40, 1'b1, 1'b1, 1'b1));
        send_item(make_item(FUNC_PIN_EVENT, 32'd50, 1'b1, 1'b1, 1'b1));  // no change
        send_item(make_item(FUNC_PIN_EVENT, 32'd60, 1'b0, 1'b0, 1'b1));  // illegal jump
        send_item(make_item(FUNC_POLL, 32'd70, 1'b0, 1'b0, 1'b1));
        send_item(make_item(FUNC_PIN_EVENT, 32'd80, 1'b0, 1'b1, 1'b1));
        send_item(make_item(FUNC_PIN_EVENT, 32'd90, 1'b1, 1'b1, 1'b1));
        send_item(make_item(FUNC_PIN_EVENT, 32'd100, 1'b1, 1'b0, 1'b1));
        send_item(make_item(FUNC_PIN_EVENT, 32'd110, 1'b0, 1'b0, 1'b1));
        send_item(make_item(FUNC_POLL, 32'd120, 1'b1, 1'b1, 1'b1));
        send_item(make_item(FUNC_POLL, 32'd130, 1'b1, 1'b0, 1'b0));       // press
        send_item(make_item(FUNC_POLL, 32'd140, 1'b0, 1'b1, 1'b1));       // release bounce
        send_item(make_item(FUNC_POLL, 32'd150, 1'b1, 1'b1, 1'b0));
        send_item(make_item(FUNC_POLL, 32'd260, 1'b1, 1'b1, 1'b1));       // click
        send_item(make_item(FUNC_POLL, 32'd290, 1'b1, 1'b1, 1'b0));       // press bounce
        send_item(make_item(FUNC_POLL, 32'd300, 1'b1, 1'b1, 1'b1));       // already reported
        send_item(make_item(FUNC_POLL, 32'd400, 1'b1, 1'b1, 1'b0));
        send_item(make_item(FUNC_POLL, 32'd1300, 1'b1, 1'b1, 1'b0));      // long while held
        send_item(make_item(FUNC_POLL, 32'd1400, 1'b1, 1'b1, 1'b1));
        send_item(make_item(FUNC_POLL, 32'd1500, 1'b1, 1'b1, 1'b0));
        send_item(make_item(FUNC_POLL, 32'd2400, 1'b1, 1'b1, 1'b1));      // long on release
        now_ms   = 32'd2400;
        quad_idx = 2'd2;
        sw_pin   = 1'b1;

        // back-to-back forward edges at one timestamp, then a single report
        configure(16'd0, RST_DEBOUNCE, RST_LONG_PRESS);
        no_idle = 1'b1;
        for (int k = 0; k < BURST_STEPS; k++) begin
            quad_idx   = quad_idx + 2'd1;
            burst_pins = quad_pins(quad_idx);
            send_item(make_item(FUNC_PIN_EVENT, now_ms, burst_pins[1], burst_pins[0],
                                1'b1));
        end
        send_item(make_item(FUNC_POLL, now_ms, 1'b0, 1'b0, 1'b1));
        no_idle = 1'b0;

        configure(16'd0, 16'd0, 16'd0);
        rx_hold_asked++;
        run_random_phase(250);

        configure({8'($urandom_range(0, 255)), 8'd255}, 16'hFFFF, 16'hFFFF);
        run_random_phase(250);

        write_reg(CFG_SPARE, 16'($urandom()));
        configure({8'($urandom_range(0, 255)), 8'($urandom_range(1, 20))},
                  16'($urandom_range(1, 200)), 16'($urandom_range(100, 2000)));
        rx_hold_asked++;
        run_random_phase(250);

        configure(16'(RST_EDGE_LOCKOUT), RST_DEBOUNCE, RST_LONG_PRESS);
        run_random_phase(250);

        @(negedge clk) in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        $display("%0d transactions sent, %0d results checked, %0d register settings",
                 items_sent, checked, settings_used);
        $display("button: %0d clicks, %0d long presses; %0d back-to-back forward edges",
                 clicks, longs, BURST_STEPS);
        if (fail_count == 0 && pending == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
